// ----- hw/rtl/esfd_pkg.sv -----
package esfd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_CHATTER_HEADER = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_OFFSET  = 8'd1;

  localparam logic [7:0] CHATTER_HEADER_RST = 8'd240;
  localparam logic [7:0] LENGTH_OFFSET_RST  = 8'd85;

  // Largest payload a frame can carry
  localparam logic [7:0] MAX_PAYLOAD = 8'd170;

  // Fixed header bytes
  localparam logic [7:0] HDR_PRIMARY = 8'h80;
  localparam logic [7:0] HDR_ALT_A   = 8'h90;
  localparam logic [7:0] HDR_ALT_B   = 8'h0a;

  // Classification constants
  localparam logic [7:0] CRC_IDLE   = 8'h2a;
  localparam logic [7:0] CRC_M1_REQ = 8'h29;
  localparam logic [8:0] LEN_SHORT  = 9'd4;
  localparam logic [8:0] LEN_M1_DAT = 9'd67;
  localparam logic [8:0] LEN_M3_REQ = 9'd10;
  localparam logic [8:0] LEN_M3_DAT = 9'd7;
  localparam logic [8:0] LEN_M4_REQ = 9'd14;
  localparam logic [7:0] MODE_1     = 8'h01;
  localparam logic [7:0] MODE_3     = 8'h03;
  localparam logic [7:0] MODE_4     = 8'h04;
  localparam logic [7:0] MODE_10    = 8'h0a;

  // Deframer phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CHECK   = 2'd3;

  // Byte kinds
  localparam logic [2:0] KIND_DROP    = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_CHECK   = 3'd4;

  // Frame classes
  localparam logic [3:0] CLS_NONE    = 4'd0;
  localparam logic [3:0] CLS_IDLE    = 4'd1;
  localparam logic [3:0] CLS_M1_REQ  = 4'd2;
  localparam logic [3:0] CLS_M1_DAT  = 4'd3;
  localparam logic [3:0] CLS_M3_REQ  = 4'd4;
  localparam logic [3:0] CLS_M3_DAT  = 4'd5;
  localparam logic [3:0] CLS_M4_REQ  = 4'd6;
  localparam logic [3:0] CLS_M4_DAT  = 4'd7;
  localparam logic [3:0] CLS_M10_REQ = 4'd8;

  // Pick the first matching class for a finished frame
  function automatic logic [3:0] classify(input logic [8:0] total, input logic [7:0] hdr,
                                          input logic [7:0] mode, input logic [7:0] crc);
    logic [3:0] cls;
    cls = CLS_NONE;
    if (hdr == HDR_PRIMARY && total == LEN_SHORT && crc == CRC_IDLE) cls = CLS_IDLE;
    else if (total == LEN_SHORT && mode == MODE_1 && crc == CRC_M1_REQ) cls = CLS_M1_REQ;
    else if (total == LEN_M1_DAT && mode == MODE_1) cls = CLS_M1_DAT;
    else if (total == LEN_M3_REQ && mode == MODE_3) cls = CLS_M3_REQ;
    else if (total == LEN_M3_DAT && mode == MODE_3) cls = CLS_M3_DAT;
    else if (total == LEN_M4_REQ && mode == MODE_4) cls = CLS_M4_REQ;
    else if (total == LEN_SHORT && mode == MODE_4) cls = CLS_M4_DAT;
    else if (total == LEN_SHORT && mode == MODE_10) cls = CLS_M10_REQ;
    return cls;
  endfunction

endpackage

// ----- hw/rtl/esfd_if.sv -----
// Received byte channel
interface esfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Framed byte result channel
interface esfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [2:0] byte_kind;
  logic [7:0] payload_index;
  logic [7:0] payload_length;
  logic       frame_done;
  logic       checksum_ok;
  logic [3:0] frame_class;
  logic [7:0] mode_byte;

  modport source (output valid, output byte_out, output byte_kind, output payload_index,
                  output payload_length, output frame_done, output checksum_ok,
                  output frame_class, output mode_byte, input ready);
  modport sink (input valid, input byte_out, input byte_kind, input payload_index,
                input payload_length, input frame_done, input checksum_ok,
                input frame_class, input mode_byte, output ready);
endinterface

// Configuration write channel
interface esfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [esfd_pkg::CFG_INDEX_W-1:0]  index;
  logic [7:0]                        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ecu_serial_frame_deframer_unit.sv -----
// Channel  Dir  Beat payload
// -------  ---  ---------------------------------------------------------------
// rx       in   rx_byte
// res      out  byte_out, byte_kind, payload_index, payload_length,
//               frame_done, checksum_ok, frame_class, mode_byte
// cfg      in   index, data (0 chatter_header, 1 length_offset)
//
// Every rx beat yields exactly one res beat through the result register; one byte per cycle while res is not stalled.
// The rate is set by the single result register: rx is ready whenever it is
// empty or being drained in the same cycle.
// rst is synchronous, active high: returns to first-header hunting, registers to
// their reset values. cfg is always ready.
module ecu_serial_frame_deframer_unit (
  input  logic            clk,
  input  logic            rst,
  esfd_rx_if.sink         rx,
  esfd_res_if.source      res,
  esfd_cfg_if.sink        cfg
);

  logic [7:0] chatter_header;
  logic [7:0] length_offset;

  logic [1:0] phase, phase_next;
  logic       hunting_first, hunting_first_next;
  logic [7:0] payload_len, payload_len_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] header_seen, header_seen_next;
  logic [7:0] mode_seen, mode_seen_next;

  logic       res_valid;
  logic       take;
  logic       hdr_ok;
  logic [7:0] len_n;
  logic [7:0] count_inc;
  logic [2:0] kind_next;
  logic [7:0] pidx_next;
  logic [7:0] plen_next;
  logic       done_next;
  logic       ok_next;
  logic [3:0] cls_next;

  // Accept while the result register is free or draining
  assign rx.ready  = !res_valid || res.ready;
  assign take      = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chatter_header <= esfd_pkg::CHATTER_HEADER_RST;
      length_offset  <= esfd_pkg::LENGTH_OFFSET_RST;
    end else if (cfg.valid) begin
      if (cfg.index == esfd_pkg::REG_CHATTER_HEADER) chatter_header <= cfg.data;
      else if (cfg.index == esfd_pkg::REG_LENGTH_OFFSET) length_offset <= cfg.data;
    end
  end

  // Header match and clamped payload length
  always_comb begin
    hdr_ok = (rx.rx_byte == esfd_pkg::HDR_PRIMARY) || (rx.rx_byte == chatter_header) ||
             (!hunting_first && (rx.rx_byte == esfd_pkg::HDR_ALT_A ||
                                 rx.rx_byte == esfd_pkg::HDR_ALT_B));
    if (rx.rx_byte > length_offset) len_n = rx.rx_byte - length_offset;
    else len_n = 8'd0;
    if (len_n > esfd_pkg::MAX_PAYLOAD) len_n = esfd_pkg::MAX_PAYLOAD;
    count_inc = payload_count + 8'd1;
  end

  // Framing step for one byte
  always_comb begin
    phase_next         = phase;
    hunting_first_next = hunting_first;
    payload_len_next   = payload_len;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    header_seen_next   = header_seen;
    mode_seen_next     = mode_seen;
    kind_next          = esfd_pkg::KIND_DROP;
    pidx_next          = 8'd0;
    plen_next          = 8'd0;
    done_next          = 1'b0;
    ok_next            = 1'b0;
    cls_next           = esfd_pkg::CLS_NONE;
    case (phase)
      esfd_pkg::PH_HEADER: begin
        if (hdr_ok) begin
          hunting_first_next = 1'b0;
          header_seen_next   = rx.rx_byte;
          running_sum_next   = rx.rx_byte;
          mode_seen_next     = 8'd0;
          payload_len_next   = 8'd0;
          payload_count_next = 8'd0;
          phase_next         = esfd_pkg::PH_LENGTH;
          kind_next          = esfd_pkg::KIND_HEADER;
        end
      end
      esfd_pkg::PH_LENGTH: begin
        payload_len_next   = len_n;
        payload_count_next = 8'd0;
        running_sum_next   = running_sum + rx.rx_byte;
        phase_next         = (len_n == 8'd0) ? esfd_pkg::PH_CHECK : esfd_pkg::PH_PAYLOAD;
        kind_next          = esfd_pkg::KIND_LENGTH;
        plen_next          = len_n;
      end
      esfd_pkg::PH_PAYLOAD: begin
        if (payload_count == 8'd0) mode_seen_next = rx.rx_byte;
        pidx_next          = payload_count;
        running_sum_next   = running_sum + rx.rx_byte;
        payload_count_next = count_inc;
        if (count_inc >= payload_len) phase_next = esfd_pkg::PH_CHECK;
        kind_next          = esfd_pkg::KIND_PAYLOAD;
        plen_next          = payload_len;
      end
      default: begin
        if (payload_len == 8'd0) mode_seen_next = rx.rx_byte;
        running_sum_next   = running_sum + rx.rx_byte;
        ok_next            = (running_sum_next == 8'd0);
        cls_next           = esfd_pkg::classify({1'b0, payload_len} + 9'd3, header_seen,
                                                mode_seen_next, rx.rx_byte);
        if (!ok_next) hunting_first_next = 1'b1;
        kind_next          = esfd_pkg::KIND_CHECK;
        done_next          = 1'b1;
        plen_next          = payload_len;
        phase_next         = esfd_pkg::PH_HEADER;
        payload_len_next   = 8'd0;
        payload_count_next = 8'd0;
      end
    endcase
  end

  // Advance frame state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= esfd_pkg::PH_HEADER;
      hunting_first <= 1'b1;
      payload_len   <= 8'd0;
      payload_count <= 8'd0;
      running_sum   <= 8'd0;
      header_seen   <= 8'd0;
      mode_seen     <= 8'd0;
    end else if (take) begin
      phase         <= phase_next;
      hunting_first <= hunting_first_next;
      payload_len   <= payload_len_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      header_seen   <= header_seen_next;
      mode_seen     <= mode_seen_next;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (take) res_valid <= 1'b1;
    else if (res.ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.byte_out       <= rx.rx_byte;
      res.byte_kind      <= kind_next;
      res.payload_index  <= pidx_next;
      res.payload_length <= plen_next;
      res.frame_done     <= done_next;
      res.checksum_ok    <= ok_next;
      res.frame_class    <= cls_next;
      res.mode_byte      <= (kind_next == esfd_pkg::KIND_DROP ||
                             kind_next == esfd_pkg::KIND_HEADER) ? 8'd0 : mode_seen_next;
    end
  end

  a_done_on_check: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_done |-> res.byte_kind == esfd_pkg::KIND_CHECK)
    else $error("frame_done on a byte that is not a checksum");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.checksum_ok |-> res.frame_done)
    else $error("checksum_ok outside a frame end");

  a_payload_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == esfd_pkg::PH_PAYLOAD |-> payload_len != 8'd0 && payload_count < payload_len)
    else $error("payload phase with count past length");

  a_check_returns: assert property (@(posedge clk) disable iff (rst)
    take && phase == esfd_pkg::PH_CHECK |=> phase == esfd_pkg::PH_HEADER)
    else $error("checksum byte did not return to header phase");

  a_bad_sum_hunts: assert property (@(posedge clk) disable iff (rst)
    take && phase == esfd_pkg::PH_CHECK && !ok_next |=> hunting_first)
    else $error("bad checksum did not restart first-header hunting");

endmodule

// ----- test/esfd_frame_monitor.sv -----
`timescale 1ns / 100ps

module esfd_frame_monitor
  import esfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  esfd_rx_if          rx,
  esfd_res_if         res,
  esfd_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int unsigned REPORT_LIMIT = 10;
  // header, length and checksum bytes around the payload
  localparam logic [8:0] FRAME_OVERHEAD = 9'd3;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_kind;
    logic [7:0] payload_index;
    logic [7:0] payload_length;
    logic       frame_done;
    logic       checksum_ok;
    logic [3:0] frame_class;
    logic [7:0] mode_byte;
  } framed_beat_t;

  framed_beat_t framed_beats_due[$];

  // Register copies
  logic [7:0] chatter_hdr;
  logic [7:0] len_offset;

  // Deframer state
  logic [1:0] phase;
  logic       hunting;
  logic [7:0] payload_len;
  logic [7:0] payload_cnt;
  logic [7:0] byte_sum;
  logic [7:0] hdr_byte;
  logic [7:0] mode_val;

  int unsigned  fail_count = 0;
  framed_beat_t seen;
  framed_beat_t want;

  assign mismatches = fail_count;

  // First matching class wins; past the two short-frame rules the mode picks the group
  function automatic logic [3:0] frame_class_for(input logic [8:0] total,
                                                 input logic [7:0] hdr,
                                                 input logic [7:0] mode,
                                                 input logic [7:0] crc);
    logic short_frame;
    short_frame = (total == LEN_SHORT);
    if (short_frame && hdr == HDR_PRIMARY && crc == CRC_IDLE) return CLS_IDLE;
    if (short_frame && mode == MODE_1 && crc == CRC_M1_REQ) return CLS_M1_REQ;
    case (mode)
      MODE_1: begin
        if (total == LEN_M1_DAT) return CLS_M1_DAT;
      end
      MODE_3: begin
        if (total == LEN_M3_REQ) return CLS_M3_REQ;
        if (total == LEN_M3_DAT) return CLS_M3_DAT;
      end
      MODE_4: begin
        if (total == LEN_M4_REQ) return CLS_M4_REQ;
        if (short_frame) return CLS_M4_DAT;
      end
      MODE_10: begin
        if (short_frame) return CLS_M10_REQ;
      end
      default: ;
    endcase
    return CLS_NONE;
  endfunction

  // Advance the deframer by one received byte and return the beat it should emit
  function automatic framed_beat_t deframe_byte(input logic [7:0] b);
    framed_beat_t r;
    logic [7:0]   count;
    r = '0;
    r.byte_out = b;
    case (phase)
      PH_HEADER: begin
        if (b == HDR_PRIMARY || b == chatter_hdr ||
            (!hunting && (b == HDR_ALT_A || b == HDR_ALT_B))) begin
          hunting     = 1'b0;
          hdr_byte    = b;
          byte_sum    = b;
          mode_val    = '0;
          payload_len = '0;
          payload_cnt = '0;
          phase       = PH_LENGTH;
          r.byte_kind = KIND_HEADER;
        end else begin
          r.byte_kind = KIND_DROP;
        end
      end
      PH_LENGTH: begin
        // clamp the decoded count to 0..MAX_PAYLOAD
        count = (b > len_offset) ? b - len_offset : '0;
        if (count > MAX_PAYLOAD) count = MAX_PAYLOAD;
        payload_len      = count;
        payload_cnt      = '0;
        byte_sum         = byte_sum + b;
        phase            = (count == '0) ? PH_CHECK : PH_PAYLOAD;
        r.byte_kind      = KIND_LENGTH;
        r.payload_length = count;
      end
      PH_PAYLOAD: begin
        if (payload_cnt == '0) mode_val = b;
        r.payload_index  = payload_cnt;
        byte_sum         = byte_sum + b;
        payload_cnt      = payload_cnt + 8'd1;
        if (payload_cnt >= payload_len) phase = PH_CHECK;
        r.byte_kind      = KIND_PAYLOAD;
        r.payload_length = payload_len;
      end
      default: begin
        // checksum byte; with an empty payload it doubles as the mode byte
        if (payload_len == '0) mode_val = b;
        byte_sum         = byte_sum + b;
        r.checksum_ok    = (byte_sum == '0);
        r.frame_class    = frame_class_for({1'b0, payload_len} + FRAME_OVERHEAD,
                                           hdr_byte, mode_val, b);
        if (!r.checksum_ok) hunting = 1'b1;
        r.byte_kind      = KIND_CHECK;
        r.frame_done     = 1'b1;
        r.payload_length = payload_len;
        phase            = PH_HEADER;
        payload_len      = '0;
        payload_cnt      = '0;
      end
    endcase
    if (r.byte_kind != KIND_DROP && r.byte_kind != KIND_HEADER) r.mode_byte = mode_val;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      chatter_hdr = CHATTER_HEADER_RST;
      len_offset  = LENGTH_OFFSET_RST;
      phase       = PH_HEADER;
      hunting     = 1'b1;
      payload_len = '0;
      payload_cnt = '0;
      byte_sum    = '0;
      hdr_byte    = '0;
      mode_val    = '0;
      framed_beats_due.delete();
    end else begin
      // Register writes; unknown indexes are ignored
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_CHATTER_HEADER) chatter_hdr = cfg.data;
        else if (cfg.index == REG_LENGTH_OFFSET) len_offset = cfg.data;
      end

      if (rx.valid && rx.ready) framed_beats_due.push_back(deframe_byte(rx.rx_byte));

      // Compare each result beat with the oldest prediction
      if (res.valid && res.ready) begin
        seen = {res.byte_out, res.byte_kind, res.payload_index, res.payload_length,
                res.frame_done, res.checksum_ok, res.frame_class, res.mode_byte};
        if (framed_beats_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result beat with nothing pending: byte=%h kind=%0d",
                     $time, seen.byte_out, seen.byte_kind);
        end else begin
          want = framed_beats_due.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: result beat differs for byte %h", $time, want.byte_out);
              $display("  expected byte=%h kind=%0d idx=%0d len=%0d done=%b ok=%b cls=%0d mode=%h",
                       want.byte_out, want.byte_kind, want.payload_index, want.payload_length,
                       want.frame_done, want.checksum_ok, want.frame_class, want.mode_byte);
              $display("  actual   byte=%h kind=%0d idx=%0d len=%0d done=%b ok=%b cls=%0d mode=%h",
                       seen.byte_out, seen.byte_kind, seen.payload_index, seen.payload_length,
                       seen.frame_done, seen.checksum_ok, seen.frame_class, seen.mode_byte);
            end
          end
        end
      end
    end
    outstanding <= framed_beats_due.size();
  end

endmodule

// ----- test/ecu_serial_frame_deframer_unit_tb.sv -----
`timescale 1ns / 100ps

module ecu_serial_frame_deframer_unit_tb;
  import esfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned IDLE_PCT       = 25;
  localparam int unsigned HOLD_AT        = 80;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned CALM_FROM      = 300;
  localparam int unsigned CALM_TO        = 420;
  localparam int unsigned FRAME_OVERHEAD = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = REG_LENGTH_OFFSET + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP   = '1;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned beats_sent;
  int unsigned frame_bytes;
  logic [7:0]  cur_chatter;
  logic [7:0]  cur_offset;

  esfd_rx_if  rx ();
  esfd_res_if res ();
  esfd_cfg_if cfg ();

  ecu_serial_frame_deframer_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  esfd_frame_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .res         (res),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, one long hold-off, and a calm stretch
  initial begin
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) taken++;
      if (rst) begin
        res.ready <= 1'b0;
      end else if (!held && taken >= HOLD_AT) begin
        // hold off so the block backs up into rx
        held = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (taken >= CALM_FROM && taken < CALM_TO) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one byte, idling at random first, and wait for the beat
  task automatic send_byte(input logic [7:0] b);
    while (!(beats_sent >= CALM_FROM && beats_sent < CALM_TO) &&
           $urandom_range(99) < IDLE_PCT) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    beats_sent++;
  endtask

  // Send header, length, payload led by the mode byte, then a good or broken checksum
  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len_b,
                            input logic [7:0] mode, input bit good);
    int unsigned n;
    logic [7:0]  sum;
    logic [7:0]  b;
    n = (len_b > cur_offset) ? int'(len_b) - int'(cur_offset) : 0;
    if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
    send_byte(hdr);
    send_byte(len_b);
    sum = hdr + len_b;
    for (int i = 0; i < n; i++) begin
      b = (i == 0) ? mode : 8'($urandom);
      send_byte(b);
      sum = sum + b;
    end
    b = -sum;
    if (!good) b = b + 8'($urandom_range(1, 255));
    send_byte(b);
    frame_bytes += n + FRAME_OVERHEAD;
  endtask

  task automatic random_frame(input bit good);
    logic [7:0]  hdr;
    logic [7:0]  len_b;
    logic [7:0]  mode;
    int unsigned n;
    int unsigned pick;
    case ($urandom_range(9))
      0, 1, 2, 3: hdr = HDR_PRIMARY;
      4, 5:       hdr = cur_chatter;
      6:          hdr = HDR_ALT_A;
      7:          hdr = HDR_ALT_B;
      default:    hdr = 8'($urandom);
    endcase
    // mostly short payloads, some at the class lengths, rarely up to the maximum
    pick = $urandom_range(99);
    if (pick < 40) begin
      n = $urandom_range(4);
    end else if (pick < 60) begin
      case ($urandom_range(4))
        0:       n = LEN_SHORT - FRAME_OVERHEAD;
        1:       n = LEN_M3_DAT - FRAME_OVERHEAD;
        2:       n = LEN_M3_REQ - FRAME_OVERHEAD;
        3:       n = LEN_M4_REQ - FRAME_OVERHEAD;
        default: n = LEN_M1_DAT - FRAME_OVERHEAD;
      endcase
    end else if (pick < 97) begin
      n = $urandom_range(20);
    end else begin
      n = $urandom_range(MAX_PAYLOAD);
    end
    len_b = (int'(cur_offset) + n > 255) ? 8'hff : 8'(int'(cur_offset) + n);
    // raw length bytes reach below the offset and past the maximum
    if ($urandom_range(99) < 15) len_b = 8'($urandom);
    case ($urandom_range(7))
      0, 1:    mode = MODE_1;
      2:       mode = MODE_3;
      3:       mode = MODE_4;
      4:       mode = MODE_10;
      default: mode = 8'($urandom);
    endcase
    send_frame(hdr, len_b, mode, good);
  endtask

  // Mostly good frames, some with broken checksums, the rest line noise
  task automatic random_traffic(input int unsigned upto);
    int unsigned pick;
    while (frame_bytes < upto) begin
      pick = $urandom_range(99);
      if (pick < 75) random_frame(1'b1);
      else if (pick < 88) random_frame(1'b0);
      else send_byte(8'($urandom));
    end
    rx.valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_CHATTER_HEADER) cur_chatter = val;
    else if (idx == REG_LENGTH_OFFSET) cur_offset = val;
    @(posedge clk);
  endtask

  // Wait until every predicted beat has come out
  task automatic wait_drain();
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    rst         <= 1'b1;
    rx.valid    <= 1'b0;
    rx.rx_byte  <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= '0;
    cfg.data    <= '0;
    beats_sent  = 0;
    frame_bytes = 0;
    cur_chatter = CHATTER_HEADER_RST;
    cur_offset  = LENGTH_OFFSET_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before any frame the alternate headers and junk are dropped
    send_byte(HDR_ALT_A);
    send_byte(HDR_ALT_B);
    send_byte(8'h00);
    send_byte(8'hff);
    // Idle frame (zero mode byte) and a mode 1 request, both summing to zero
    send_frame(HDR_PRIMARY, LENGTH_OFFSET_RST + 8'd1, '0, 1'b1);
    send_frame(HDR_PRIMARY, LENGTH_OFFSET_RST + 8'd1, MODE_1, 1'b1);
    // Alternate header now accepted; length below the offset leaves no payload
    send_frame(HDR_ALT_A, 8'h00, '0, 1'b1);
    // Mode 3 data frame on the chatter header with a bad checksum
    send_frame(CHATTER_HEADER_RST, LENGTH_OFFSET_RST + 8'd4, MODE_3, 1'b0);
    // Back to hunting, so this one is dropped
    send_byte(HDR_ALT_B);
    // Length equal to the offset: empty payload again
    send_frame(HDR_PRIMARY, LENGTH_OFFSET_RST, MODE_4, 1'b1);

    random_traffic(130);
    wait_drain();

    // Low extremes, plus a write to an unused index
    write_reg(REG_CHATTER_HEADER, '0);
    write_reg(REG_LENGTH_OFFSET, '0);
    write_reg(REG_SPARE, 8'($urandom));
    // Length byte past the maximum saturates the payload count
    send_frame(HDR_PRIMARY, 8'hff, MODE_1, 1'b1);
    random_traffic(330);
    wait_drain();

    // High extremes: every frame has an empty payload
    write_reg(REG_CHATTER_HEADER, '1);
    write_reg(REG_LENGTH_OFFSET, '1);
    write_reg(REG_TOP, 8'($urandom));
    random_traffic(440);
    wait_drain();

    // Chatter header colliding with a fixed header, random offset
    write_reg(REG_CHATTER_HEADER, HDR_ALT_A);
    write_reg(REG_LENGTH_OFFSET, 8'($urandom_range(1, 254)));
    random_traffic(560);
    wait_drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/esfd_pkg.sv
hw/rtl/esfd_if.sv
hw/rtl/ecu_serial_frame_deframer_unit.sv
test/esfd_frame_monitor.sv
test/ecu_serial_frame_deframer_unit_tb.sv
